@@ rtl/core/ksdp_pkg.sv @@
package ksdp_pkg;

  localparam int CapW    = 10;
  localparam int WeightW = 10;
  localparam int ValueW  = 16;
  localparam int BestW   = 32;
  localparam int DataW   = 32;
  localparam int PaddrW  = 3;

  localparam int DefMaxCapacity = 1023;
  localparam int DefValueBits   = 16;

  localparam logic [CapW-1:0] CapacityReset = CapW'(1023);

  localparam logic [PaddrW-3:0] RegCapacity = '0;

endpackage

@@ rtl/core/ksdp_row_mem.sv @@
module ksdp_row_mem #(
  parameter int Depth = ksdp_pkg::DefMaxCapacity + 1,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [AddrW-1:0]           wr_addr_i,
  input  logic [ksdp_pkg::BestW-1:0] wr_data_i,
  input  logic [AddrW-1:0]           rda_addr_i,
  output logic [ksdp_pkg::BestW-1:0] rda_data_o,
  input  logic [AddrW-1:0]           rdb_addr_i,
  output logic [ksdp_pkg::BestW-1:0] rdb_data_o
);
  import ksdp_pkg::*;

  logic [BestW-1:0] mem [Depth];
  logic [BestW-1:0] rda_q;
  logic [BestW-1:0] rdb_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rda_q <= mem[rda_addr_i];
    rdb_q <= mem[rdb_addr_i];
  end

  assign rda_data_o = rda_q;
  assign rdb_data_o = rdb_q;

endmodule

@@ rtl/core/knapsack_01_dp_engine.sv @@
// Channel   Direction  Handshake                Words
// in        input      in_valid_i / in_stall_o  weight_i, value_i, last_i
// out       output     out_valid_o / out_stall_i best_value_o
// cfg       input      APB psel/penable/pready  capacity at byte address 0
//
// An item is accepted in S_IDLE; S_RUN then writes each row entry from the capacity down
// to max(weight, 1), one write per cycle, and S_DRAIN completes the last write. An item
// with max(weight, 1) above the capacity skips both. A last item adds a read of the
// full-capacity entry, a result state and a clearing sweep of MAX_CAPACITY + 1 entries,
// which after reset also runs before the first word is taken. A stalled result waits
// in the output register while work goes on; only a second result waits for it.
module knapsack_01_dp_engine #(
  parameter int MAX_CAPACITY = ksdp_pkg::DefMaxCapacity,
  parameter int VALUE_BITS   = ksdp_pkg::DefValueBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ksdp_pkg::WeightW-1:0]  weight_i,
  input  logic [ksdp_pkg::ValueW-1:0]   value_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ksdp_pkg::BestW-1:0]    best_value_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ksdp_pkg::PaddrW-1:0]   paddr,
  input  logic [ksdp_pkg::DataW-1:0]    pwdata,
  output logic [ksdp_pkg::DataW-1:0]    prdata,
  output logic                          pready
);
  import ksdp_pkg::*;

  localparam int Depth = MAX_CAPACITY + 1;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CmpW  = (AddrW > CapW) ? AddrW : CapW;
  localparam logic [AddrW-1:0]  MaxAddr = AddrW'(MAX_CAPACITY);
  localparam logic [ValueW-1:0] ValMask = (VALUE_BITS >= ValueW) ? '1 :
                                          ValueW'((32'd1 << VALUE_BITS) - 32'd1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_READ,
    S_RESULT
  } state_e;

  state_e              state_q;
  logic [AddrW-1:0]    j_q;
  logic [AddrW-1:0]    cap_q;
  logic [WeightW-1:0]  w_q;
  logic [ValueW-1:0]   v_q;
  logic                last_q;
  logic                p1_vld_q;
  logic [AddrW-1:0]    p1_addr_q;
  logic                out_valid_q;
  logic [BestW-1:0]    best_value_q;
  logic [CapW-1:0]     capacity_q;

  logic                cfg_wr;
  logic                in_accept;
  logic                out_free;
  logic [CmpW-1:0]     cap_ext;
  logic [AddrW-1:0]    cap_eff;
  logic [CmpW-1:0]     w_ext_in;
  logic [CmpW-1:0]     lo_in;
  logic [CmpW-1:0]     lo_q;
  logic                item_runs;

  logic                wr_en;
  logic [AddrW-1:0]    wr_addr;
  logic [BestW-1:0]    wr_data;
  logic [AddrW-1:0]    rda_addr;
  logic [AddrW-1:0]    rdb_addr;
  logic [BestW-1:0]    rda_data;
  logic [BestW-1:0]    rdb_data;
  logic [BestW:0]      sum;
  logic [BestW-1:0]    cand;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PaddrW-1:2] == RegCapacity);
  assign prdata = (paddr[PaddrW-1:2] == RegCapacity) ? DataW'(capacity_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapacityReset;
    end else if (cfg_wr) begin
      capacity_q <= pwdata[CapW-1:0];
    end
  end

  // Item set-up.
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cap_ext    = (CmpW'(capacity_q) > CmpW'(MAX_CAPACITY)) ? CmpW'(MAX_CAPACITY)
                                                               : CmpW'(capacity_q);
  assign cap_eff    = cap_ext[AddrW-1:0];
  assign w_ext_in   = CmpW'(weight_i);
  assign lo_in      = (weight_i == '0) ? CmpW'(1) : w_ext_in;
  assign item_runs  = (w_ext_in <= cap_ext) && (lo_in <= cap_ext);
  assign lo_q       = (w_q == '0) ? CmpW'(1) : CmpW'(w_q);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Memory ports.
  assign rda_addr = ((state_q == S_READ) || (state_q == S_RESULT)) ? cap_q : j_q;
  assign rdb_addr = AddrW'(CmpW'(j_q) - CmpW'(w_q));
  assign sum      = {1'b0, rdb_data} + (BestW + 1)'(v_q);
  assign cand     = sum[BestW] ? '1 : sum[BestW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p1_addr_q;
    wr_data = (cand > rda_data) ? cand : rda_data;
    if (state_q == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = j_q;
      wr_data = '0;
    end else if (p1_vld_q) begin
      wr_en = 1'b1;
    end
  end

  ksdp_row_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_row_mem (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .rda_addr_i (rda_addr),
    .rda_data_o (rda_data),
    .rdb_addr_i (rdb_addr),
    .rdb_data_o (rdb_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      j_q          <= MaxAddr;
      cap_q        <= '0;
      w_q          <= '0;
      v_q          <= '0;
      last_q       <= 1'b0;
      p1_vld_q     <= 1'b0;
      p1_addr_q    <= '0;
      out_valid_q  <= 1'b0;
      best_value_q <= '0;
    end else begin
      p1_vld_q    <= (state_q == S_RUN);
      p1_addr_q   <= j_q;
      out_valid_q <= ((state_q == S_RESULT) && out_free) || (out_valid_q && out_stall_i);
      unique case (state_q)
        S_CLEAR: begin
          if (j_q == '0) begin
            state_q <= S_IDLE;
          end else begin
            j_q <= j_q - AddrW'(1);
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            cap_q  <= cap_eff;
            w_q    <= weight_i;
            v_q    <= value_i & ValMask;
            last_q <= last_i;
            j_q    <= cap_eff;
            if (item_runs) begin
              state_q <= S_RUN;
            end else if (last_i) begin
              state_q <= S_READ;
            end
          end
        end
        S_RUN: begin
          j_q <= j_q - AddrW'(1);
          if (CmpW'(j_q) == lo_q) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_q <= last_q ? S_READ : S_IDLE;
        end
        S_READ: begin
          state_q <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            best_value_q <= rda_data;
            j_q          <= MaxAddr;
            state_q      <= S_CLEAR;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign best_value_o = best_value_q;

  a_no_write_entry0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p1_vld_q |-> (p1_addr_q != '0))
    else $error("update wrote entry zero");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !wr_en)
    else $error("row write while idle");

  a_shift_read_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (rdb_addr <= j_q))
    else $error("shifted read above current entry");

  a_result_then_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (state_q == S_CLEAR))
    else $error("result issued without clearing the row");

endmodule
